### rtl/linear_key_value_store_top_macros.svh
// Assertion macros shared by the key/value store RTL.
// Included by every module that carries concurrent checks; no other dependency.
`ifndef LINEAR_KEY_VALUE_STORE_TOP_MACROS_SVH
`define LINEAR_KEY_VALUE_STORE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Check that is switched off while the reset is asserted.
`define LKVS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("lkvs check failed");
// Check that also holds while the reset is asserted.
`define LKVS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lkvs check failed");
`else
`define LKVS_ASSERT(lbl, clk, rstn, prop)
`define LKVS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### rtl/lkvs_pkg.sv
// Types and constants of the linear key/value store.
// Used by lkvs_ctrl, lkvs_dp and linear_key_value_store_top; depends on nothing.
package lkvs_pkg;

  localparam int KEY_W   = 16;
  localparam int VALUE_W = 32;
  localparam int OP_W    = 2;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_READ   = 2'd0;
  localparam op_t OP_WRITE  = 2'd1;
  localparam op_t OP_DELETE = 2'd2;
  localparam op_t OP_FORMAT = 2'd3;

  localparam logic [KEY_W-1:0]   KEY_EMPTY    = 16'h0000;
  localparam logic [KEY_W-1:0]   KEY_ERASED   = 16'hFFFF;
  localparam logic [VALUE_W-1:0] VALUE_ERASED = 32'hFFFF_FFFF;

  // Packed word widths, padded to whole bytes.
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 40;

  // Commands from the controller.
  typedef struct packed {
    logic load;      // capture the accepted word
    logic erase;     // clearing pass: erase the entry at the counter
    logic scan_rd;   // read the entry at the counter for the scan
    logic commit;    // write back the chosen slot
    logic out_load;  // hand the result to the output register
  } cmd_t;

  // Status towards the controller.
  typedef struct packed {
    op_t  op;
    logic formatted;
    logic cnt_last;
  } sts_t;

  typedef struct packed {
    logic                      success;
    logic                      key_found;
    logic signed [VALUE_W-1:0] read_value;
  } res_t;

endpackage

### rtl/lkvs_ctrl.sv
// Sequencer of the linear key/value store: clearing pass, scan, write-back, hand-over.
// Depends on lkvs_pkg and linear_key_value_store_top_macros.svh.
`include "linear_key_value_store_top_macros.svh"

module lkvs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          out_free_i,
  input  lkvs_pkg::sts_t sts_i,
  output lkvs_pkg::cmd_t cmd_o
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_COMMIT = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.erase = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Format, and anything before the first format, needs no scan.
        if (sts_i.op == lkvs_pkg::OP_FORMAT || !sts_i.formatted) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.scan_rd = 1'b1;
          if (sts_i.cnt_last) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (sts_i.op == lkvs_pkg::OP_WRITE || sts_i.op == lkvs_pkg::OP_DELETE) begin
          state_d = ST_COMMIT;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  `LKVS_ASSERT(a_commit_after_drain, clk_i, rst_ni, cmd_o.commit |-> $past(state_q) == ST_DRAIN)
  `LKVS_ASSERT(a_ready_after_handover, clk_i, rst_ni, $rose(in_ready_o) |-> $past(cmd_o.out_load || cmd_o.erase))

endmodule

### rtl/lkvs_dp.sv
// Datapath of the linear key/value store: key and value memories, scan counter,
// match and free-slot tracking and result forming. Depends on lkvs_pkg and the macro header.
`include "linear_key_value_store_top_macros.svh"

module lkvs_dp #(
  parameter int NUM_RECORDS = 128
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lkvs_pkg::cmd_t                       cmd_i,
  input  lkvs_pkg::op_t                        op_i,
  input  logic        [lkvs_pkg::KEY_W-1:0]    key_i,
  input  logic signed [lkvs_pkg::VALUE_W-1:0]  new_value_i,
  input  logic signed [lkvs_pkg::VALUE_W-1:0]  default_value_i,
  output lkvs_pkg::sts_t                       sts_o,
  output lkvs_pkg::res_t                       res_o
);

  localparam int IW = (NUM_RECORDS > 1) ? $clog2(NUM_RECORDS) : 1;

  logic [lkvs_pkg::KEY_W-1:0]   key_mem [NUM_RECORDS];
  logic [lkvs_pkg::VALUE_W-1:0] val_mem [NUM_RECORDS];

  lkvs_pkg::op_t                op_q;
  logic [lkvs_pkg::KEY_W-1:0]   key_q;
  logic [lkvs_pkg::VALUE_W-1:0] newv_q, defv_q;
  logic                         formatted_q;

  logic [IW-1:0] cnt_q, cmp_idx_q;
  logic          cnt_last;
  logic          cmp_vld_q;
  logic [lkvs_pkg::KEY_W-1:0]   key_rd_q;
  logic [lkvs_pkg::VALUE_W-1:0] val_rd_q;

  logic          hit_q, have_free_q;
  logic [IW-1:0] slot_q, free_slot_q;
  logic [lkvs_pkg::VALUE_W-1:0] hit_val_q;

  logic                         match, empty, usable, we;
  logic [IW-1:0]                wr_addr;
  logic [lkvs_pkg::KEY_W-1:0]   wr_key;
  logic [lkvs_pkg::VALUE_W-1:0] wr_val;

  assign cnt_last = (cnt_q == IW'(NUM_RECORDS - 1));
  assign match    = cmp_vld_q && (key_rd_q == key_q);
  assign empty    = cmp_vld_q &&
                    (key_rd_q == lkvs_pkg::KEY_EMPTY || key_rd_q == lkvs_pkg::KEY_ERASED);
  assign usable   = hit_q || have_free_q;

  // Input capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      key_q  <= key_i;
      newv_q <= new_value_i;
      defv_q <= default_value_i;
    end
  end

  // Control state: counter, format flag and the scan bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      formatted_q <= 1'b0;
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      have_free_q <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.scan_rd;
      if (cmd_i.erase || cmd_i.scan_rd) begin
        cnt_q <= cnt_last ? '0 : cnt_q + IW'(1);
      end
      if (cmd_i.load && op_i == lkvs_pkg::OP_FORMAT) begin
        formatted_q <= 1'b1;
      end
      if (cmd_i.load) begin
        hit_q       <= 1'b0;
        have_free_q <= 1'b0;
      end else begin
        if (match) begin
          hit_q <= 1'b1;
        end
        if (empty) begin
          have_free_q <= 1'b1;
        end
      end
    end
  end

  // Only the first match and the first empty slot are kept.
  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cnt_q;
    if (match && !hit_q) begin
      slot_q    <= cmp_idx_q;
      hit_val_q <= val_rd_q;
    end
    if (empty && !have_free_q) begin
      free_slot_q <= cmp_idx_q;
    end
  end

  // Write port: erase during the clearing pass, otherwise the write-back.
  always_comb begin
    we      = 1'b0;
    wr_addr = hit_q ? slot_q : free_slot_q;
    wr_key  = lkvs_pkg::KEY_ERASED;
    wr_val  = lkvs_pkg::VALUE_ERASED;
    if (cmd_i.erase) begin
      we      = 1'b1;
      wr_addr = cnt_q;
    end else if (cmd_i.commit && usable) begin
      we = 1'b1;
      if (op_q == lkvs_pkg::OP_WRITE) begin
        wr_key = key_q;
        wr_val = newv_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
    key_rd_q <= key_mem[cnt_q];
    val_rd_q <= val_mem[cnt_q];
  end

  always_comb begin
    sts_o.op        = op_q;
    sts_o.formatted = formatted_q;
    sts_o.cnt_last  = cnt_last;

    res_o.key_found  = hit_q;
    res_o.success    = (op_q == lkvs_pkg::OP_FORMAT) ||
                       (op_q != lkvs_pkg::OP_READ && formatted_q && usable);
    res_o.read_value = '0;
    if (op_q == lkvs_pkg::OP_READ) begin
      res_o.read_value = hit_q ? hit_val_q : defv_q;
    end
  end

  `LKVS_ASSERT(a_hit_from_compare, clk_i, rst_ni, $rose(hit_q) |-> $past(cmp_vld_q))
  `LKVS_ASSERT(a_commit_formatted, clk_i, rst_ni, (cmd_i.commit && usable) |-> formatted_q)

endmodule

### rtl/linear_key_value_store_top.sv
// Top level of the linear key/value store: stream ports, output register and
// the controller/datapath pair. Depends on lkvs_pkg, lkvs_ctrl, lkvs_dp and the macro header.
//
// Usage. Commands arrive as words on the slave stream (s_axis_*) and each one
// gives exactly one result word on the master stream (m_axis_*). A command is a
// read, write, delete or format of a table of NUM_RECORDS key/value records.
// Every read, write and delete of a formatted store walks the whole table, one
// record per clock, through the single read port of the key and value memories;
// after the walk the last compare is drained, a write or delete then writes its
// slot back, and the result is offered from the output register. A format, and
// any command before the first format, needs no walk. One command is worked on
// at a time: s_axis_tready is high only while the block is waiting for work, so
// no new word is accepted until the result of the last has been handed over.
// After reset the block erases every record to all ones, one per cycle, and
// accepts the first word only once that pass is done; the store starts
// unformatted. The result sits in an output register: while the receiver stalls,
// the next command may already be accepted and worked on, and its result waits
// until the register has been emptied.
`include "linear_key_value_store_top_macros.svh"

module linear_key_value_store_top #(
  parameter int NUM_RECORDS = 128
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // From bit 0 up: operation[1:0], lookup_key[15:0], new_value[31:0],
  // default_value[31:0], zero padding.
  input  logic [lkvs_pkg::IN_DATA_W-1:0] s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // From bit 0 up: success, key_found, read_value[31:0], zero padding.
  output logic [lkvs_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  lkvs_pkg::cmd_t cmd;
  lkvs_pkg::sts_t sts;
  lkvs_pkg::res_t res;

  logic           out_vld_q;
  lkvs_pkg::res_t out_q;
  logic           out_free;

  // The output register may be loaded when empty or emptied in the same cycle.
  assign out_free = !out_vld_q || m_axis_tready;

  lkvs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lkvs_dp #(
    .NUM_RECORDS (NUM_RECORDS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .op_i            (s_axis_tdata[1:0]),
    .key_i           (s_axis_tdata[17:2]),
    .new_value_i     (s_axis_tdata[49:18]),
    .default_value_i (s_axis_tdata[81:50]),
    .sts_o           (sts),
    .res_o           (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd.out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, out_q.read_value, out_q.key_found, out_q.success};

  // A new word is never taken in the cycle straight after one was accepted.
  `LKVS_ASSERT(a_one_word_in_flight, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)

endmodule
